// ----- rtl/ufmc_pkg.sv -----
// shared types, constants and controller/datapath interface for the maze carver
`default_nettype none

package ufmc_pkg;

  // fixed field widths
  localparam int unsigned CELL_W       = 10;
  localparam int unsigned CFG_W        = 6;
  localparam int unsigned COORD_W      = 5;
  localparam int unsigned MAX_SIDE_DEF = 32;

  localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(15);

  // command codes
  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_EDGE    = 1'b1;

  // input transaction
  typedef struct packed {
    logic              command;
    logic [CELL_W-1:0] cell_a;
    logic [CELL_W-1:0] cell_b;
  } item_t;

  // result transaction
  typedef struct packed {
    logic               merged;
    logic [COORD_W-1:0] open_col;
    logic [COORD_W-1:0] open_row;
    logic               bad_cell;
  } result_t;

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_FIND_HALVE,
    ST_LINK,
    ST_DIV_A,
    ST_DIV_B,
    ST_REPLY
  } state_e;

  // current-cell register update
  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_A,
    CUR_B,
    CUR_PARENT
  } cur_op_e;

  // parent table read
  typedef enum logic [1:0] {
    RD_NONE,
    RD_CUR,
    RD_PARENT
  } rd_op_e;

  // parent table write
  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_HALVE,
    WR_LINK
  } wr_op_e;

  // kind of result to load
  typedef enum logic [1:0] {
    REP_NONE,
    REP_BAD,
    REP_MERGED
  } reply_e;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    cur_op_e cur_op;
    rd_op_e  rd_op;
    wr_op_e  wr_op;
    logic    save_root_a;
    logic    div_start;
    logic    div_sel_b;
    logic    div_save_a;
    logic    res_load;
    reply_e  res_kind;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic restart;
    logic bad;
    logic at_root;
    logic roots_differ;
    logic clr_last;
    logic div_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/ufmc_div.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none

module ufmc_div #(
  parameter int unsigned NUM_W = 10,
  parameter int unsigned DEN_W = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quot_o,
  output logic      [DEN_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             run_q, run_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // one shift-subtract step
  always_comb begin
    trial  = {rem_q, quot_q[NUM_W-1]};
    diff   = trial - {1'b0, den_q};
    fits   = (trial >= {1'b0, den_q});
    run_d  = run_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (run_q) begin
      rem_d  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot_d = {quot_q[NUM_W-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = !run_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- rtl/ufmc_ctrl.sv -----
// controller state machine for the maze carver
`default_nettype none

module ufmc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire ufmc_pkg::dp_sts_t  sts_i,
  output ufmc_pkg::dp_cmd_t       cmd_o
);

  ufmc_pkg::state_e state_q, state_d;
  logic             find_b_q, find_b_d;
  logic             reply_q, reply_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ufmc_pkg::ST_CLEAR;
      find_b_q <= 1'b0;
      reply_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      find_b_q <= find_b_d;
      reply_q  <= reply_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d           = state_q;
    find_b_d          = find_b_q;
    reply_d           = reply_q;
    cmd_o             = '0;
    cmd_o.cur_op      = ufmc_pkg::CUR_HOLD;
    cmd_o.rd_op       = ufmc_pkg::RD_NONE;
    cmd_o.wr_op       = ufmc_pkg::WR_NONE;
    cmd_o.res_kind    = ufmc_pkg::REP_NONE;
    case (state_q)
      ufmc_pkg::ST_CLEAR: begin
        // one table entry per cycle back to its own index
        cmd_o.wr_op = ufmc_pkg::WR_CLEAR;
        if (sts_i.clr_last) begin
          cmd_o.res_load = reply_q;
          reply_d        = 1'b0;
          state_d        = ufmc_pkg::ST_IDLE;
        end
      end
      ufmc_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ufmc_pkg::ST_CHECK;
        end
      end
      ufmc_pkg::ST_CHECK: begin
        if (sts_i.restart) begin
          reply_d = 1'b1;
          state_d = ufmc_pkg::ST_CLEAR;
        end else if (sts_i.bad) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = ufmc_pkg::REP_BAD;
          state_d        = ufmc_pkg::ST_IDLE;
        end else begin
          cmd_o.cur_op = ufmc_pkg::CUR_A;
          find_b_d     = 1'b0;
          state_d      = ufmc_pkg::ST_FIND_RD;
        end
      end
      ufmc_pkg::ST_FIND_RD: begin
        cmd_o.rd_op = ufmc_pkg::RD_CUR;
        state_d     = ufmc_pkg::ST_FIND_CHK;
      end
      ufmc_pkg::ST_FIND_CHK: begin
        if (sts_i.at_root) begin
          if (!find_b_q) begin
            cmd_o.save_root_a = 1'b1;
            cmd_o.cur_op      = ufmc_pkg::CUR_B;
            find_b_d          = 1'b1;
            state_d           = ufmc_pkg::ST_FIND_RD;
          end else begin
            state_d = ufmc_pkg::ST_LINK;
          end
        end else begin
          // fetch the grandparent
          cmd_o.rd_op = ufmc_pkg::RD_PARENT;
          state_d     = ufmc_pkg::ST_FIND_HALVE;
        end
      end
      ufmc_pkg::ST_FIND_HALVE: begin
        cmd_o.wr_op  = ufmc_pkg::WR_HALVE;
        cmd_o.cur_op = ufmc_pkg::CUR_PARENT;
        state_d      = ufmc_pkg::ST_FIND_RD;
      end
      ufmc_pkg::ST_LINK: begin
        if (sts_i.roots_differ) begin
          cmd_o.wr_op     = ufmc_pkg::WR_LINK;
          cmd_o.div_start = 1'b1;
          state_d         = ufmc_pkg::ST_DIV_A;
        end else begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = ufmc_pkg::REP_NONE;
          state_d        = ufmc_pkg::ST_IDLE;
        end
      end
      ufmc_pkg::ST_DIV_A: begin
        if (sts_i.div_done) begin
          cmd_o.div_save_a = 1'b1;
          cmd_o.div_start  = 1'b1;
          cmd_o.div_sel_b  = 1'b1;
          state_d          = ufmc_pkg::ST_DIV_B;
        end
      end
      ufmc_pkg::ST_DIV_B: begin
        if (sts_i.div_done) begin
          state_d = ufmc_pkg::ST_REPLY;
        end
      end
      ufmc_pkg::ST_REPLY: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_kind = ufmc_pkg::REP_MERGED;
        state_d        = ufmc_pkg::ST_IDLE;
      end
      default: begin
        state_d = ufmc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ufmc_pkg::ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/ufmc_dp.sv -----
// datapath: parent table, walk registers, divider and result register
`default_nettype none

module ufmc_dp #(
  parameter int unsigned MAX_SIDE = ufmc_pkg::MAX_SIDE_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ufmc_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire ufmc_pkg::item_t                item_i,
  input  wire ufmc_pkg::dp_cmd_t              cmd_i,
  output ufmc_pkg::dp_sts_t                   sts_o,
  output logic                                res_valid_o,
  output ufmc_pkg::result_t                   res_o
);

  localparam int unsigned DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned CELL_W = ufmc_pkg::CELL_W;
  localparam int unsigned CFG_W  = ufmc_pkg::CFG_W;
  localparam int unsigned CMP_W  = (2 * SIDE_W > CELL_W) ? 2 * SIDE_W : CELL_W;

  // parent table and walk registers
  logic [IDX_W-1:0]  parent_q [DEPTH];
  logic [IDX_W-1:0]  rdata_q;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [IDX_W-1:0]  root_a_q;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic [CFG_W-1:0]  grid_q;
  ufmc_pkg::item_t   item_q;
  logic [SIDE_W-1:0] xa_q;
  logic [CELL_W-1:0] ya_q;
  ufmc_pkg::result_t res_q, res_d;
  logic              res_valid_q;

  logic              mem_we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  a_idx;
  logic [IDX_W-1:0]  b_idx;

  logic [CFG_W:0]    grid_x;
  logic [CFG_W:0]    max_x;
  logic [CFG_W:0]    side_full;
  logic [SIDE_W-1:0] side;
  logic [2*SIDE_W-1:0] cells;

  logic              div_done;
  logic [CELL_W-1:0] div_quot;
  logic [SIDE_W-1:0] div_rem;
  logic [CELL_W-1:0] div_num;
  logic [SIDE_W-1:0] col_full;
  logic [CELL_W-1:0] row_full;

  // grid side, saturated at MAX_SIDE
  always_comb begin
    grid_x    = {1'b0, grid_q};
    max_x     = (CFG_W + 1)'(MAX_SIDE);
    side_full = (grid_x > max_x) ? max_x : grid_x;
    side      = SIDE_W'(side_full);
    cells     = (2 * SIDE_W)'(side) * (2 * SIDE_W)'(side);
  end

  assign a_idx = IDX_W'(item_q.cell_a);
  assign b_idx = IDX_W'(item_q.cell_b);

  // status towards the controller
  always_comb begin
    sts_o              = '0;
    sts_o.restart      = (item_q.command == ufmc_pkg::CMD_RESTART);
    sts_o.bad          = (CMP_W'(item_q.cell_a) >= CMP_W'(cells)) ||
                         (CMP_W'(item_q.cell_b) >= CMP_W'(cells));
    sts_o.at_root      = (rdata_q == cur_q);
    sts_o.roots_differ = (root_a_q != cur_q);
    sts_o.clr_last     = (clr_q == IDX_W'(DEPTH - 1));
    sts_o.div_done     = div_done;
  end

  // table port selection
  always_comb begin
    mem_we = 1'b0;
    waddr  = clr_q;
    wdata  = clr_q;
    clr_d  = clr_q;
    case (cmd_i.wr_op)
      ufmc_pkg::WR_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = sts_o.clr_last ? '0 : clr_q + IDX_W'(1);
      end
      ufmc_pkg::WR_HALVE: begin
        mem_we = 1'b1;
        waddr  = cur_q;
        wdata  = rdata_q;
      end
      ufmc_pkg::WR_LINK: begin
        mem_we = 1'b1;
        waddr  = root_a_q;
        wdata  = cur_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    mem_re = 1'b0;
    raddr  = cur_q;
    case (cmd_i.rd_op)
      ufmc_pkg::RD_CUR: begin
        mem_re = 1'b1;
      end
      ufmc_pkg::RD_PARENT: begin
        mem_re = 1'b1;
        raddr  = rdata_q;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // parent table write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      parent_q[waddr] <= wdata;
    end
  end

  // parent table read port
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= parent_q[raddr];
    end
  end

  // current cell of the walk
  always_comb begin
    case (cmd_i.cur_op)
      ufmc_pkg::CUR_A:      cur_d = a_idx;
      ufmc_pkg::CUR_B:      cur_d = b_idx;
      ufmc_pkg::CUR_PARENT: cur_d = rdata_q;
      default:              cur_d = cur_q;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.save_root_a) begin
      root_a_q <= cur_q;
    end
    if (cmd_i.div_save_a) begin
      xa_q <= div_rem;
      ya_q <= div_quot;
    end
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
  end

  // clear counter, side register and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      grid_q      <= ufmc_pkg::GRID_RESET;
      res_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      res_valid_q <= cmd_i.res_load;
      if (cfg_we_i) begin
        grid_q <= cfg_data_i;
      end
    end
  end

  // split a cell index into column and row
  assign div_num = cmd_i.div_sel_b ? item_q.cell_b : item_q.cell_a;

  ufmc_div #(
    .NUM_W (CELL_W),
    .DEN_W (SIDE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (side),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // cell to open: shared column takes the smaller row, else the smaller column on cell a's row
  always_comb begin
    if (xa_q == div_rem) begin
      col_full = xa_q;
      row_full = (ya_q < div_quot) ? ya_q : div_quot;
    end else begin
      col_full = (xa_q < div_rem) ? xa_q : div_rem;
      row_full = ya_q;
    end
    res_d = '0;
    case (cmd_i.res_kind)
      ufmc_pkg::REP_BAD: begin
        res_d.bad_cell = 1'b1;
      end
      ufmc_pkg::REP_MERGED: begin
        res_d.merged   = 1'b1;
        res_d.open_col = ufmc_pkg::COORD_W'(col_full);
        res_d.open_row = ufmc_pkg::COORD_W'(row_full);
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- rtl/union_find_maze_carver_top.sv -----
// Kruskal maze carver over a union-find parent table: top level.
// Transactions are taken one at a time: a command is accepted when start is high while busy
// is low, and exactly one result appears on res_o for a single cycle with res_valid_o high; the
// receiver must take it then, as there is no way to hold it off. After reset, and after every
// restart command, the parent table is rewritten one entry per cycle, all MAX_SIDE*MAX_SIDE
// entries (1024 at the default size), during which busy stays high; a restart reports its result
// at the end of that pass. An edge first goes through the range check in the CHECK state, and an
// edge with a cell index outside the grid replies from there. Otherwise each root search walks
// the table with path halving in the FIND_RD, FIND_CHK and FIND_HALVE states, since every table
// read is registered before its value can be checked, and the LINK state then compares the two
// roots; a same-set edge replies from there. A merge adds two divisions on the shared bit-serial
// divider that turns the cell indices into column and row, and REPLY forms the result. The user
// must write grid_side through cfg_we_i and cfg_data_i only while the block is idle; not enforced.
`default_nettype none

module union_find_maze_carver_top #(
  parameter int unsigned MAX_SIDE = ufmc_pkg::MAX_SIDE_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire ufmc_pkg::item_t            item_i,
  output logic                            res_valid_o,
  output ufmc_pkg::result_t               res_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [ufmc_pkg::CFG_W-1:0] cfg_data_i
);

  ufmc_pkg::dp_cmd_t dp_cmd;
  ufmc_pkg::dp_sts_t dp_sts;

  // sequencer
  ufmc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (dp_sts),
    .cmd_o   (dp_cmd)
  );

  // table and arithmetic
  ufmc_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ----- rtl/ufmc_chk.sv -----
// port-level checker for the maze carver, bound to the top level
`default_nettype none

module ufmc_chk (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       res_valid_o,
  input wire ufmc_pkg::result_t          res_o
);

  // an accepted transaction keeps the block busy in the next cycle
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result is only given once the block is free again
  a_result_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result strobe while busy");

  // results never come in consecutive cycles
  a_result_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held for more than one cycle");

  // an out-of-grid edge never merges
  a_bad_no_merge : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.bad_cell) |-> !res_o.merged)
    else $error("bad cell reported together with a merge");

  // no coordinates without a merge
  a_coord_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.merged) |-> (res_o.open_col == '0 && res_o.open_row == '0))
    else $error("open cell reported without a merge");

endmodule

bind union_find_maze_carver_top ufmc_chk u_ufmc_chk (.*);

`default_nettype wire

// ----- tb/union_find_maze_carver_top_tb.sv -----
// testbench for the union-find maze carver: queued stimulus, clocked driver and result checker
`timescale 1ns / 1ps

module union_find_maze_carver_top_tb;
  import ufmc_pkg::*;

  localparam int unsigned TBL_DEPTH    = MAX_SIDE_DEF * MAX_SIDE_DEF;
  localparam int unsigned STALL_LIMIT  = 40000;
  localparam int unsigned TARGET_ITEMS = 1000;

  // one queued stimulus step: either a grid side write or a command transaction
  typedef struct {
    bit                is_cfg;
    logic [CFG_W-1:0]  side_val;
    item_t             it;
    int unsigned       gap;
  } job_t;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             start      = 1'b0;
  logic             busy;
  item_t            item_i     = '0;
  logic             res_valid_o;
  result_t          res_o;
  logic             cfg_we_i   = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  job_t             pending_q[$];
  result_t          carve_exp_q[$];
  logic [CELL_W-1:0] parent_tbl[TBL_DEPTH];
  logic [CFG_W-1:0] side_cfg = GRID_RESET;
  int unsigned      sent_cnt  = 0;
  int unsigned      taken_cnt = 0;
  int unsigned      err_cnt   = 0;
  int unsigned      gap_left  = 0;
  int unsigned      stall_cnt = 0;
  int unsigned      idle_mode = 1;
  int unsigned      n_items   = 0;

  union_find_maze_carver_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // every cell back in its own set
  function automatic void clear_sets();
    for (int unsigned k = 0; k < TBL_DEPTH; k++) parent_tbl[k] = CELL_W'(k);
  endfunction

  // root search with path halving, updating the table on the way
  function automatic logic [CELL_W-1:0] find_root(logic [CELL_W-1:0] c);
    logic [CELL_W-1:0] up;
    while (parent_tbl[c] != c) begin
      up = parent_tbl[c];
      parent_tbl[c] = parent_tbl[up];
      c = parent_tbl[c];
    end
    return c;
  endfunction

  // expected result of one command, applied to the shadow table
  function automatic result_t carve_predict(item_t it);
    result_t           r;
    int unsigned       sd, cells, xa, ya, xb, yb, col, row;
    logic [CELL_W-1:0] ra, rb;
    r = '0;
    sd = (side_cfg > MAX_SIDE_DEF) ? MAX_SIDE_DEF : side_cfg;
    cells = sd * sd;
    if (it.command == CMD_RESTART) begin
      clear_sets();
      return r;
    end
    if (it.cell_a >= cells || it.cell_b >= cells) begin
      r.bad_cell = 1'b1;
      return r;
    end
    ra = find_root(it.cell_a);
    rb = find_root(it.cell_b);
    if (ra == rb) return r;
    parent_tbl[ra] = rb;
    xa = it.cell_a % sd;
    ya = it.cell_a / sd;
    xb = it.cell_b % sd;
    yb = it.cell_b / sd;
    if (xa == xb) begin
      col = xa;
      row = (ya < yb) ? ya : yb;
    end else begin
      col = (xa < xb) ? xa : xb;
      row = ya;
    end
    r.merged   = 1'b1;
    r.open_col = COORD_W'(col);
    r.open_row = COORD_W'(row);
    return r;
  endfunction

  task automatic add_item(logic cmd, int unsigned a, int unsigned b);
    job_t j;
    j.is_cfg    = 1'b0;
    j.side_val  = '0;
    j.it.command = cmd;
    j.it.cell_a = CELL_W'(a);
    j.it.cell_b = CELL_W'(b);
    j.gap       = (idle_mode == 0) ? 0 : $urandom_range(0, 8);
    pending_q   = {pending_q, j};
    n_items++;
  endtask

  task automatic add_side(int unsigned v);
    job_t j;
    j.is_cfg   = 1'b1;
    j.side_val = CFG_W'(v);
    j.it       = '0;
    j.gap      = 0;
    pending_q  = {pending_q, j};
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    logic nx_start;
    logic nx_we;
    job_t j;
    nx_start = start;
    nx_we    = 1'b0;
    if (rst_ni) begin
      if (start && taken_cnt != sent_cnt) begin
        // transaction still waiting for the block
      end else if (gap_left != 0) begin
        nx_start = 1'b0;
        gap_left--;
      end else if (pending_q.size() != 0) begin
        if (pending_q[0].is_cfg) begin
          nx_start = 1'b0;
          // side is only changed with the block idle and nothing outstanding
          if (!start && !busy && carve_exp_q.size() == 0) begin
            j = pending_q.pop_front();
            nx_we = 1'b1;
            cfg_data_i <= j.side_val;
          end
        end else begin
          j = pending_q.pop_front();
          nx_start = 1'b1;
          item_i <= j.it;
          sent_cnt++;
          gap_left = j.gap;
        end
      end else begin
        nx_start = 1'b0;
      end
    end
    start    <= nx_start;
    cfg_we_i <= nx_we;
  end

  // monitor: sample on the rising edge, check results, predict accepted commands
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni) begin
      stall_cnt++;
      if (res_valid_o) begin
        stall_cnt = 0;
        if (carve_exp_q.size() == 0) begin
          $error("result with no transaction outstanding: %p", res_o);
          err_cnt++;
        end else begin
          e = carve_exp_q.pop_front();
          if (res_o.merged !== e.merged) begin
            $error("merged: expected %0d, got %0d", e.merged, res_o.merged);
            err_cnt++;
          end
          if (res_o.open_col !== e.open_col) begin
            $error("open_col: expected %0d, got %0d", e.open_col, res_o.open_col);
            err_cnt++;
          end
          if (res_o.open_row !== e.open_row) begin
            $error("open_row: expected %0d, got %0d", e.open_row, res_o.open_row);
            err_cnt++;
          end
          if (res_o.bad_cell !== e.bad_cell) begin
            $error("bad_cell: expected %0d, got %0d", e.bad_cell, res_o.bad_cell);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        stall_cnt = 0;
        taken_cnt++;
        carve_exp_q = {carve_exp_q, carve_predict(item_i)};
      end
      if (cfg_we_i) begin
        stall_cnt = 0;
        side_cfg = cfg_data_i;
      end
      // watchdog
      if (stall_cnt >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned ea[2048];
    int unsigned eb[2048];
    int unsigned n_edges, lim, eff, s_cfg, pick, roll, j, t;
    clear_sets();

    // directed: default side of 15
    add_item(CMD_EDGE, 0, 1);
    add_item(CMD_EDGE, 1, 0);
    add_item(CMD_EDGE, 224, 223);
    add_item(CMD_EDGE, 225, 3);
    add_item(CMD_EDGE, 5, 1023);
    add_item(CMD_RESTART, 1023, 1023);
    // widest grid, top corner cells, non-adjacent pair
    add_side(32);
    add_item(CMD_EDGE, 1023, 1022);
    add_item(CMD_EDGE, 0, 32);
    add_item(CMD_EDGE, 1023, 0);
    add_item(CMD_EDGE, 31, 992);
    // side above the limit saturates
    add_side(63);
    add_item(CMD_EDGE, 991, 1023);
    // side zero and one
    add_side(0);
    add_item(CMD_EDGE, 0, 0);
    add_side(1);
    add_item(CMD_EDGE, 0, 0);
    add_item(CMD_EDGE, 0, 1);
    // smallest real grid: full maze then a same-set edge
    add_side(2);
    add_item(CMD_RESTART, 0, 0);
    add_item(CMD_EDGE, 0, 1);
    add_item(CMD_EDGE, 2, 3);
    add_item(CMD_EDGE, 3, 1);
    add_item(CMD_EDGE, 0, 2);
    // side changed with the maze kept
    add_side(5);
    add_item(CMD_EDGE, 6, 1);
    add_item(CMD_EDGE, 0, 5);

    // random phases: mostly shuffled grid edges, some noise
    while (n_items < TARGET_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) s_cfg = 32;
      else if (pick == 1) s_cfg = 2;
      else if (pick == 2) s_cfg = $urandom_range(33, 63);
      else if (pick == 3) s_cfg = $urandom_range(0, 1);
      else if (pick < 7) s_cfg = $urandom_range(9, 32);
      else s_cfg = $urandom_range(2, 8);
      idle_mode = $urandom_range(0, 2);
      add_side(s_cfg);
      if ($urandom_range(0, 5) != 0) add_item(CMD_RESTART, $urandom, $urandom);
      eff = (s_cfg > MAX_SIDE_DEF) ? MAX_SIDE_DEF : s_cfg;
      n_edges = 0;
      for (int unsigned c = 0; c < eff * eff; c++) begin
        if (c % eff != eff - 1) begin
          ea[n_edges] = c;
          eb[n_edges] = c + 1;
          n_edges++;
        end
        if (c / eff != eff - 1) begin
          ea[n_edges] = c;
          eb[n_edges] = c + eff;
          n_edges++;
        end
      end
      for (int unsigned i = n_edges; i > 1; i--) begin
        j = $urandom_range(0, i - 1);
        t = ea[i-1]; ea[i-1] = ea[j]; ea[j] = t;
        t = eb[i-1]; eb[i-1] = eb[j]; eb[j] = t;
      end
      if (n_edges == 0) lim = $urandom_range(3, 8);
      else if (n_edges < 60) lim = n_edges;
      else lim = $urandom_range(40, 80);
      for (int unsigned i = 0; i < lim; i++) begin
        roll = (n_edges == 0) ? $urandom_range(0, 1) : $urandom_range(0, 19);
        if (roll == 0) add_item(CMD_EDGE, $urandom_range(0, 1023), $urandom_range(0, 1023));
        else if (roll == 1 && eff != 0)
          add_item(CMD_EDGE, $urandom_range(0, eff * eff - 1), $urandom_range(0, eff * eff - 1));
        else if (roll == 1) add_item(CMD_EDGE, $urandom_range(0, 3), $urandom_range(0, 3));
        else if (roll == 2 && $urandom_range(0, 3) == 0) add_item(CMD_RESTART, $urandom, $urandom);
        else if (i < n_edges && $urandom_range(0, 1) == 0) add_item(CMD_EDGE, eb[i], ea[i]);
        else if (i < n_edges) add_item(CMD_EDGE, ea[i], eb[i]);
        else add_item(CMD_EDGE, $urandom_range(0, 1023), $urandom_range(0, 1023));
      end
    end

    // reset held at the start, released on a falling edge
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain, then let the block settle
    while (pending_q.size() != 0 || taken_cnt != sent_cnt || start || carve_exp_q.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
